// File: sv/ebc_pkg.sv
// ebc_pkg: shared types, constants and opcode decode for the execute core
// used by ebc_ctrl, ebc_dp and eight_bit_cpu_execute_core; no dependencies
package ebc_pkg;

  // transaction modes
  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_EXEC  = 2'd2,
    MODE_RESET = 2'd3
  } mode_e;

  // instruction classes seen by the sequencer
  typedef enum logic [3:0] {
    CLS_UNK,
    CLS_ST_IND,
    CLS_LD_IND,
    CLS_IMM1,
    CLS_IMM2,
    CLS_LD_RR,
    CLS_ALU,
    CLS_INC_DEC,
    CLS_ADD_HL,
    CLS_CTL
  } op_cls_e;

  // controller states
  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MEM_WR,
    ST_MEM_RD,
    ST_RST_REGS,
    ST_RD_IE,
    ST_RD_IF,
    ST_IRQ_CHK,
    ST_PUSH_LO,
    ST_RD_IF2,
    ST_WR_IF,
    ST_FETCH,
    ST_DECODE,
    ST_HL_RD,
    ST_EXEC,
    ST_IMM1,
    ST_IMM2,
    ST_IMMW,
    ST_IMMW2,
    ST_LDA,
    ST_FINISH,
    ST_DONE
  } state_e;

  // datapath commands, one per cycle
  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_ACCEPT,
    OP_MEM_WR,
    OP_MEM_RD,
    OP_RST_REGS,
    OP_RD_IE,
    OP_RD_IF,
    OP_IRQ_CHK,
    OP_PUSH_LO,
    OP_RD_IF2,
    OP_WR_IF,
    OP_FETCH,
    OP_DECODE,
    OP_HL_RD,
    OP_EXEC,
    OP_IMM1,
    OP_IMM2,
    OP_IMMW,
    OP_IMMW2,
    OP_LDA,
    OP_FINISH,
    OP_OUT
  } dp_op_e;

  // status from datapath to controller
  typedef struct packed {
    logic    clr_last;
    logic    ime;
    logic    pend_any;
    op_cls_e new_cls;
    logic    new_need_hl;
    op_cls_e cur_cls;
    logic    cur_load_a;
  } status_t;

  // named opcodes
  localparam logic [7:0] OPC_DI      = 8'hF3;
  localparam logic [7:0] OPC_EI      = 8'hFB;
  localparam logic [7:0] OPC_LDH_N_A = 8'hE0;
  localparam logic [7:0] OPC_LDH_A_N = 8'hF0;
  localparam logic [7:0] OPC_ADD_SP  = 8'hE8;
  localparam logic [7:0] OPC_LD_NN_A = 8'hEA;
  localparam logic [7:0] OPC_LD_A_NN = 8'hFA;
  localparam logic [7:0] OPC_JP      = 8'hC3;
  localparam logic [7:0] OPC_LD_HL_N = 8'h36;

  // fixed addresses and reset values
  localparam logic [15:0] ADDR_IE   = 16'hFFFF;
  localparam logic [15:0] ADDR_IF   = 16'hFF0F;
  localparam logic [7:0]  HIGH_PAGE = 8'hFF;
  localparam logic [15:0] VEC_BASE  = 16'h0040;
  localparam logic [15:0] SP_RESET  = 16'hFFFE;
  localparam logic [15:0] PC_RESET  = 16'h0100;
  localparam logic [15:0] CLR_LAST  = 16'hFFFF;
  localparam logic [2:0]  IDX_HL    = 3'd6;

  // opcode class
  function automatic op_cls_e decode_op(input logic [7:0] op);
    op_cls_e cls;
    case (op) inside
      8'h02, 8'h12, 8'h22, 8'h32, 8'hE2: cls = CLS_ST_IND;
      8'h0A, 8'h1A, 8'h2A, 8'h3A, 8'hF2: cls = CLS_LD_IND;
      OPC_LDH_N_A, OPC_LDH_A_N, OPC_ADD_SP,
      8'hC6, 8'hCE, 8'hD6, 8'hDE, 8'hE6, 8'hEE, 8'hF6, 8'hFE: cls = CLS_IMM1;
      OPC_LD_A_NN, OPC_LD_NN_A, OPC_JP: cls = CLS_IMM2;
      8'h09, 8'h19, 8'h29, 8'h39: cls = CLS_ADD_HL;
      OPC_DI, OPC_EI: cls = CLS_CTL;
      default: begin
        if (op[7:6] == 2'b01 && op[5:3] != IDX_HL) begin
          cls = CLS_LD_RR;
        end else if (op[7:6] == 2'b10) begin
          cls = CLS_ALU;
        end else if (op[7:6] == 2'b00 && (op[2:0] == 3'd4 || op[2:0] == 3'd5)) begin
          cls = CLS_INC_DEC;
        end else if (op[7:6] == 2'b00 && op[2:0] == 3'd6 && op != OPC_LD_HL_N) begin
          cls = CLS_IMM1;
        end else begin
          cls = CLS_UNK;
        end
      end
    endcase
    return cls;
  endfunction

  // operand comes from the byte at HL
  function automatic logic need_hl(input logic [7:0] op);
    op_cls_e cls;
    cls = decode_op(op);
    return ((cls == CLS_LD_RR || cls == CLS_ALU) && op[2:0] == IDX_HL) ||
           (cls == CLS_INC_DEC && op[5:3] == IDX_HL);
  endfunction

  // instruction ends by loading A from a memory read
  function automatic logic load_a(input logic [7:0] op);
    logic r;
    case (op) inside
      8'h0A, 8'h1A, 8'h2A, 8'h3A, 8'hF2, OPC_LDH_A_N, OPC_LD_A_NN: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// File: sv/ebc_ctrl.sv
// ebc_ctrl: sequencer state machine of the execute core
// depends on ebc_pkg; drives one datapath command per cycle
module ebc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [1:0]       in_mode_i,
  input  logic             out_ready_i,
  input  ebc_pkg::status_t status_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  output ebc_pkg::dp_op_e  op_o
);

  ebc_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ebc_pkg::ST_CLEAR: begin
        if (status_i.clr_last) state_d = ebc_pkg::ST_IDLE;
      end
      ebc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (in_mode_i)
            ebc_pkg::MODE_WRITE: state_d = ebc_pkg::ST_MEM_WR;
            ebc_pkg::MODE_READ:  state_d = ebc_pkg::ST_MEM_RD;
            ebc_pkg::MODE_EXEC:
              state_d = status_i.ime ? ebc_pkg::ST_RD_IE : ebc_pkg::ST_FETCH;
            default: state_d = ebc_pkg::ST_RST_REGS;
          endcase
        end
      end
      ebc_pkg::ST_MEM_WR, ebc_pkg::ST_MEM_RD, ebc_pkg::ST_RST_REGS:
        state_d = ebc_pkg::ST_DONE;
      ebc_pkg::ST_RD_IE: state_d = ebc_pkg::ST_RD_IF;
      ebc_pkg::ST_RD_IF: state_d = ebc_pkg::ST_IRQ_CHK;
      ebc_pkg::ST_IRQ_CHK:
        state_d = status_i.pend_any ? ebc_pkg::ST_PUSH_LO : ebc_pkg::ST_FETCH;
      ebc_pkg::ST_PUSH_LO: state_d = ebc_pkg::ST_RD_IF2;
      ebc_pkg::ST_RD_IF2:  state_d = ebc_pkg::ST_WR_IF;
      ebc_pkg::ST_WR_IF:   state_d = ebc_pkg::ST_FETCH;
      ebc_pkg::ST_FETCH:   state_d = ebc_pkg::ST_DECODE;
      ebc_pkg::ST_DECODE: begin
        if (status_i.new_cls == ebc_pkg::CLS_IMM1 || status_i.new_cls == ebc_pkg::CLS_IMM2) begin
          state_d = ebc_pkg::ST_IMM1;
        end else if (status_i.new_need_hl) begin
          state_d = ebc_pkg::ST_HL_RD;
        end else begin
          state_d = ebc_pkg::ST_EXEC;
        end
      end
      ebc_pkg::ST_HL_RD: state_d = ebc_pkg::ST_EXEC;
      ebc_pkg::ST_IMM1:
        state_d = (status_i.cur_cls == ebc_pkg::CLS_IMM2) ? ebc_pkg::ST_IMM2 : ebc_pkg::ST_IMMW;
      ebc_pkg::ST_IMM2: state_d = ebc_pkg::ST_IMMW2;
      ebc_pkg::ST_EXEC, ebc_pkg::ST_IMMW, ebc_pkg::ST_IMMW2:
        state_d = status_i.cur_load_a ? ebc_pkg::ST_LDA : ebc_pkg::ST_FINISH;
      ebc_pkg::ST_LDA:    state_d = ebc_pkg::ST_FINISH;
      ebc_pkg::ST_FINISH: state_d = ebc_pkg::ST_DONE;
      ebc_pkg::ST_DONE: begin
        if (out_free) state_d = ebc_pkg::ST_IDLE;
      end
      default: state_d = ebc_pkg::ST_IDLE;
    endcase
  end

  // outputs per state
  always_comb begin
    op_o       = ebc_pkg::OP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      ebc_pkg::ST_CLEAR: op_o = ebc_pkg::OP_CLEAR;
      ebc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) op_o = ebc_pkg::OP_ACCEPT;
      end
      ebc_pkg::ST_MEM_WR:   op_o = ebc_pkg::OP_MEM_WR;
      ebc_pkg::ST_MEM_RD:   op_o = ebc_pkg::OP_MEM_RD;
      ebc_pkg::ST_RST_REGS: op_o = ebc_pkg::OP_RST_REGS;
      ebc_pkg::ST_RD_IE:    op_o = ebc_pkg::OP_RD_IE;
      ebc_pkg::ST_RD_IF:    op_o = ebc_pkg::OP_RD_IF;
      ebc_pkg::ST_IRQ_CHK:  op_o = ebc_pkg::OP_IRQ_CHK;
      ebc_pkg::ST_PUSH_LO:  op_o = ebc_pkg::OP_PUSH_LO;
      ebc_pkg::ST_RD_IF2:   op_o = ebc_pkg::OP_RD_IF2;
      ebc_pkg::ST_WR_IF:    op_o = ebc_pkg::OP_WR_IF;
      ebc_pkg::ST_FETCH:    op_o = ebc_pkg::OP_FETCH;
      ebc_pkg::ST_DECODE:   op_o = ebc_pkg::OP_DECODE;
      ebc_pkg::ST_HL_RD:    op_o = ebc_pkg::OP_HL_RD;
      ebc_pkg::ST_EXEC:     op_o = ebc_pkg::OP_EXEC;
      ebc_pkg::ST_IMM1:     op_o = ebc_pkg::OP_IMM1;
      ebc_pkg::ST_IMM2:     op_o = ebc_pkg::OP_IMM2;
      ebc_pkg::ST_IMMW:     op_o = ebc_pkg::OP_IMMW;
      ebc_pkg::ST_IMMW2:    op_o = ebc_pkg::OP_IMMW2;
      ebc_pkg::ST_LDA:      op_o = ebc_pkg::OP_LDA;
      ebc_pkg::ST_FINISH:   op_o = ebc_pkg::OP_FINISH;
      ebc_pkg::ST_DONE: begin
        if (out_free) op_o = ebc_pkg::OP_OUT;
      end
      default: op_o = ebc_pkg::OP_NONE;
    endcase
  end

  // result valid flag
  always_comb begin
    if (op_o == ebc_pkg::OP_OUT) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ebc_pkg::ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: sv/ebc_dp.sv
// ebc_dp: register file, alu, 64K byte memory and result registers
// depends on ebc_pkg; commanded one step per cycle by ebc_ctrl
module ebc_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ebc_pkg::dp_op_e  op_i,
  input  logic [1:0]       mode_i,
  input  logic [15:0]      address_i,
  input  logic [7:0]       write_data_i,
  output ebc_pkg::status_t status_o,
  output logic [7:0]       read_data_o,
  output logic [7:0]       accumulator_o,
  output logic [7:0]       reg_b_out_o,
  output logic [7:0]       reg_c_out_o,
  output logic [7:0]       reg_d_out_o,
  output logic [7:0]       reg_e_out_o,
  output logic [7:0]       reg_h_out_o,
  output logic [7:0]       reg_l_out_o,
  output logic [15:0]      stack_pointer_out_o,
  output logic [15:0]      program_counter_out_o,
  output logic [3:0]       flags_out_o,
  output logic             unknown_opcode_o
);

  typedef enum logic [2:0] {
    ALU_ADD, ALU_ADC, ALU_SUB, ALU_SBC, ALU_AND, ALU_XOR, ALU_OR, ALU_CP
  } alu_fn_e;

  typedef struct packed {
    logic [7:0] res;
    logic       z;
    logic       h;
    logic       c;
    logic       wr;
  } alu_out_t;

  // eight-bit alu
  function automatic alu_out_t alu_f(input alu_fn_e fn, input logic [7:0] a,
                                     input logic [7:0] v, input logic cin);
    alu_out_t r;
    logic [8:0] sum;
    logic [4:0] hs;
    logic c;
    r   = '0;
    c   = 1'b0;
    sum = '0;
    hs  = '0;
    case (fn)
      ALU_ADD, ALU_ADC: begin
        c    = (fn == ALU_ADC) && cin;
        sum  = {1'b0, a} + {1'b0, v} + {8'd0, c};
        hs   = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, c};
        r.res = sum[7:0];
        r.h  = hs[4];
        r.c  = sum[8];
        r.wr = 1'b1;
      end
      ALU_SUB, ALU_SBC, ALU_CP: begin
        c    = (fn == ALU_SBC) && cin;
        sum  = {1'b0, a} - {1'b0, v} - {8'd0, c};
        hs   = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, c};
        r.res = sum[7:0];
        r.h  = hs[4];
        r.c  = sum[8];
        r.wr = (fn != ALU_CP);
      end
      ALU_AND: begin
        r.res = a & v;
        r.h  = 1'b1;
        r.wr = 1'b1;
      end
      ALU_XOR: begin
        r.res = a ^ v;
        r.wr = 1'b1;
      end
      default: begin
        r.res = a | v;
        r.wr = 1'b1;
      end
    endcase
    r.z = (r.res == 8'd0);
    return r;
  endfunction

  // architectural state
  logic [7:0]  a_q, b_q, c_q, d_q, e_q, h_q, l_q;
  logic [7:0]  a_d, b_d, c_d, d_d, e_d, h_d, l_d;
  logic [15:0] sp_q, sp_d, pc_q, pc_d;
  logic        zf_q, zf_d, hf_q, hf_d, cf_q, cf_d;
  logic        ime_q, ime_d, eip_q, eip_d;
  logic [15:0] clr_q, clr_d;

  // working registers
  logic [1:0]  mode_q;
  logic [15:0] addr_q;
  logic [7:0]  wdata_q;
  logic [7:0]  opc_q;
  logic [7:0]  tmp_lo_q;
  logic [7:0]  ie_q;
  logic [2:0]  bit_q, bit_d;
  logic        unk_q, unk_d;

  // memory port
  logic [7:0]  mem [65536];
  logic        mem_we, mem_re;
  logic [15:0] mem_addr;
  logic [7:0]  mem_wd;
  logic [7:0]  mem_rdata_q;

  // register write port
  logic        rf_we;
  logic [2:0]  rf_idx;
  logic [7:0]  rf_val;

  logic [15:0] bc, de, hl, sp_dec, hl_step, exec_addr, add_u;
  logic [2:0]  opnd_idx;
  logic [7:0]  opnd, incdec;
  logic [4:0]  pend;
  logic [2:0]  pend_idx;
  alu_out_t    alu_r;
  logic [16:0] add16;
  logic [12:0] add12;
  logic [8:0]  sp_lo;
  logic [4:0]  sp_nib;

  assign bc      = {b_q, c_q};
  assign de      = {d_q, e_q};
  assign hl      = {h_q, l_q};
  assign sp_dec  = sp_q - 16'd1;
  assign hl_step = opc_q[4] ? (hl - 16'd1) : (hl + 16'd1);

  // address for indirect loads and stores
  always_comb begin
    case (opc_q[7:4])
      4'h0:       exec_addr = bc;
      4'h1:       exec_addr = de;
      4'hE, 4'hF: exec_addr = {ebc_pkg::HIGH_PAGE, c_q};
      default:    exec_addr = hl;
    endcase
  end

  // register operand, (hl) taken from the memory read
  assign opnd_idx = (status_o.cur_cls == ebc_pkg::CLS_INC_DEC) ? opc_q[5:3] : opc_q[2:0];
  always_comb begin
    case (opnd_idx)
      3'd0:    opnd = b_q;
      3'd1:    opnd = c_q;
      3'd2:    opnd = d_q;
      3'd3:    opnd = e_q;
      3'd4:    opnd = h_q;
      3'd5:    opnd = l_q;
      3'd6:    opnd = mem_rdata_q;
      default: opnd = a_q;
    endcase
  end

  assign incdec = opc_q[0] ? (opnd - 8'd1) : (opnd + 8'd1);

  // alu input: immediate byte or register operand
  assign alu_r = alu_f(alu_fn_e'(opc_q[5:3]), a_q,
                       (op_i == ebc_pkg::OP_IMMW) ? mem_rdata_q : opnd, cf_q);

  // 16-bit adds
  always_comb begin
    case (opc_q[5:4])
      2'd0:    add_u = bc;
      2'd1:    add_u = de;
      2'd2:    add_u = hl;
      default: add_u = sp_q;
    endcase
  end
  assign add16  = {1'b0, hl} + {1'b0, add_u};
  assign add12  = {1'b0, hl[11:0]} + {1'b0, add_u[11:0]};
  assign sp_lo  = {1'b0, sp_q[7:0]} + {1'b0, mem_rdata_q};
  assign sp_nib = {1'b0, sp_q[3:0]} + {1'b0, mem_rdata_q[3:0]};

  // lowest pending interrupt
  assign pend = ie_q[4:0] & mem_rdata_q[4:0];
  always_comb begin
    pend_idx = 3'd0;
    for (int i = 4; i >= 0; i--) begin
      if (pend[i]) pend_idx = 3'(i);
    end
  end

  // per-command next state
  always_comb begin
    a_d = a_q; b_d = b_q; c_d = c_q; d_d = d_q; e_d = e_q; h_d = h_q; l_d = l_q;
    sp_d = sp_q; pc_d = pc_q;
    zf_d = zf_q; hf_d = hf_q; cf_d = cf_q;
    ime_d = ime_q; eip_d = eip_q;
    clr_d = clr_q;
    bit_d = bit_q;
    unk_d = unk_q;
    mem_we = 1'b0; mem_re = 1'b0; mem_addr = '0; mem_wd = '0;
    rf_we = 1'b0; rf_idx = '0; rf_val = '0;
    case (op_i)
      ebc_pkg::OP_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_q;
        clr_d    = clr_q + 16'd1;
      end
      ebc_pkg::OP_ACCEPT: unk_d = 1'b0;
      ebc_pkg::OP_MEM_WR: begin
        mem_we   = 1'b1;
        mem_addr = addr_q;
        mem_wd   = wdata_q;
      end
      ebc_pkg::OP_MEM_RD: begin
        mem_re   = 1'b1;
        mem_addr = addr_q;
      end
      ebc_pkg::OP_RST_REGS: begin
        a_d = '0; b_d = '0; c_d = '0; d_d = '0; e_d = '0; h_d = '0; l_d = '0;
        sp_d = ebc_pkg::SP_RESET; pc_d = ebc_pkg::PC_RESET;
        zf_d = 1'b0; hf_d = 1'b0; cf_d = 1'b0; ime_d = 1'b0; eip_d = 1'b0;
      end
      ebc_pkg::OP_RD_IE: begin
        mem_re   = 1'b1;
        mem_addr = ebc_pkg::ADDR_IE;
      end
      ebc_pkg::OP_RD_IF, ebc_pkg::OP_RD_IF2: begin
        mem_re   = 1'b1;
        mem_addr = ebc_pkg::ADDR_IF;
      end
      ebc_pkg::OP_IRQ_CHK: begin
        bit_d = pend_idx;
        if (pend != 5'd0) begin
          mem_we   = 1'b1;
          mem_addr = sp_dec;
          mem_wd   = pc_q[15:8];
          sp_d     = sp_dec;
        end
      end
      ebc_pkg::OP_PUSH_LO: begin
        mem_we   = 1'b1;
        mem_addr = sp_dec;
        mem_wd   = pc_q[7:0];
        sp_d     = sp_dec;
        pc_d     = ebc_pkg::VEC_BASE + {10'd0, bit_q, 3'd0};
      end
      ebc_pkg::OP_WR_IF: begin
        mem_we   = 1'b1;
        mem_addr = ebc_pkg::ADDR_IF;
        mem_wd   = mem_rdata_q & ~(8'd1 << bit_q);
        ime_d    = 1'b0;
      end
      ebc_pkg::OP_FETCH, ebc_pkg::OP_IMM1, ebc_pkg::OP_IMM2: begin
        mem_re   = 1'b1;
        mem_addr = pc_q;
        pc_d     = pc_q + 16'd1;
      end
      ebc_pkg::OP_HL_RD: begin
        mem_re   = 1'b1;
        mem_addr = hl;
      end
      ebc_pkg::OP_EXEC: begin
        case (status_o.cur_cls)
          ebc_pkg::CLS_ST_IND, ebc_pkg::CLS_LD_IND: begin
            mem_addr = exec_addr;
            if (status_o.cur_cls == ebc_pkg::CLS_ST_IND) begin
              mem_we = 1'b1;
              mem_wd = a_q;
            end else begin
              mem_re = 1'b1;
            end
            if (opc_q[7:6] == 2'b00 && opc_q[5]) begin
              h_d = hl_step[15:8];
              l_d = hl_step[7:0];
            end
          end
          ebc_pkg::CLS_LD_RR: begin
            rf_we  = 1'b1;
            rf_idx = opc_q[5:3];
            rf_val = opnd;
          end
          ebc_pkg::CLS_ALU: begin
            rf_we  = alu_r.wr;
            rf_idx = 3'd7;
            rf_val = alu_r.res;
            zf_d   = alu_r.z;
            hf_d   = alu_r.h;
            cf_d   = alu_r.c;
          end
          ebc_pkg::CLS_INC_DEC: begin
            hf_d = opc_q[0] ? (opnd[3:0] == 4'h0) : (opnd[3:0] == 4'hF);
            zf_d = (incdec == 8'd0);
            if (opc_q[5:3] == ebc_pkg::IDX_HL) begin
              mem_we   = 1'b1;
              mem_addr = hl;
              mem_wd   = incdec;
            end else begin
              rf_we  = 1'b1;
              rf_idx = opc_q[5:3];
              rf_val = incdec;
            end
          end
          ebc_pkg::CLS_ADD_HL: begin
            hf_d = add12[12];
            cf_d = add16[16];
            h_d  = add16[15:8];
            l_d  = add16[7:0];
          end
          ebc_pkg::CLS_UNK: unk_d = 1'b1;
          default: unk_d = unk_q;
        endcase
      end
      ebc_pkg::OP_IMMW: begin
        case (opc_q)
          ebc_pkg::OPC_LDH_N_A: begin
            mem_we   = 1'b1;
            mem_addr = {ebc_pkg::HIGH_PAGE, mem_rdata_q};
            mem_wd   = a_q;
          end
          ebc_pkg::OPC_LDH_A_N: begin
            mem_re   = 1'b1;
            mem_addr = {ebc_pkg::HIGH_PAGE, mem_rdata_q};
          end
          ebc_pkg::OPC_ADD_SP: begin
            hf_d = sp_nib[4];
            cf_d = sp_lo[8];
            zf_d = 1'b0;
            sp_d = sp_q + {{8{mem_rdata_q[7]}}, mem_rdata_q};
          end
          default: begin
            if (opc_q[7:6] == 2'b11) begin
              rf_we  = alu_r.wr;
              rf_idx = 3'd7;
              rf_val = alu_r.res;
              zf_d   = alu_r.z;
              hf_d   = alu_r.h;
              cf_d   = alu_r.c;
            end else begin
              rf_we  = 1'b1;
              rf_idx = opc_q[5:3];
              rf_val = mem_rdata_q;
            end
          end
        endcase
      end
      ebc_pkg::OP_IMMW2: begin
        case (opc_q)
          ebc_pkg::OPC_LD_A_NN: begin
            mem_re   = 1'b1;
            mem_addr = {mem_rdata_q, tmp_lo_q};
          end
          ebc_pkg::OPC_LD_NN_A: begin
            mem_we   = 1'b1;
            mem_addr = {mem_rdata_q, tmp_lo_q};
            mem_wd   = a_q;
          end
          default: pc_d = {mem_rdata_q, tmp_lo_q};
        endcase
      end
      ebc_pkg::OP_LDA: a_d = mem_rdata_q;
      ebc_pkg::OP_FINISH: begin
        if (opc_q == ebc_pkg::OPC_DI) begin
          ime_d = 1'b0;
        end else if (eip_q) begin
          ime_d = 1'b1;
        end
        eip_d = (opc_q == ebc_pkg::OPC_EI);
      end
      default: unk_d = unk_q;
    endcase

    // register write port
    if (rf_we) begin
      case (rf_idx)
        3'd0:    b_d = rf_val;
        3'd1:    c_d = rf_val;
        3'd2:    d_d = rf_val;
        3'd3:    e_d = rf_val;
        3'd4:    h_d = rf_val;
        3'd5:    l_d = rf_val;
        3'd7:    a_d = rf_val;
        default: a_d = a_q;
      endcase
    end
  end

  // status toward the controller
  assign status_o.clr_last    = (clr_q == ebc_pkg::CLR_LAST);
  assign status_o.ime         = ime_q;
  assign status_o.pend_any    = (pend != 5'd0);
  assign status_o.new_cls     = ebc_pkg::decode_op(mem_rdata_q);
  assign status_o.new_need_hl = ebc_pkg::need_hl(mem_rdata_q);
  assign status_o.cur_cls     = ebc_pkg::decode_op(opc_q);
  assign status_o.cur_load_a  = ebc_pkg::load_a(opc_q);

  // architectural registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0; e_q <= '0; h_q <= '0; l_q <= '0;
      sp_q <= ebc_pkg::SP_RESET;
      pc_q <= ebc_pkg::PC_RESET;
      zf_q <= 1'b0; hf_q <= 1'b0; cf_q <= 1'b0;
      ime_q <= 1'b0; eip_q <= 1'b0;
      clr_q <= '0;
      unk_q <= 1'b0;
    end else begin
      a_q <= a_d; b_q <= b_d; c_q <= c_d; d_q <= d_d; e_q <= e_d; h_q <= h_d; l_q <= l_d;
      sp_q <= sp_d;
      pc_q <= pc_d;
      zf_q <= zf_d; hf_q <= hf_d; cf_q <= cf_d;
      ime_q <= ime_d; eip_q <= eip_d;
      clr_q <= clr_d;
      unk_q <= unk_d;
    end
  end

  // transaction and working registers
  always_ff @(posedge clk_i) begin
    bit_q <= bit_d;
    if (op_i == ebc_pkg::OP_ACCEPT) begin
      mode_q  <= mode_i;
      addr_q  <= address_i;
      wdata_q <= write_data_i;
    end
    if (op_i == ebc_pkg::OP_DECODE) opc_q <= mem_rdata_q;
    if (op_i == ebc_pkg::OP_IMM2) tmp_lo_q <= mem_rdata_q;
    if (op_i == ebc_pkg::OP_RD_IF) ie_q <= mem_rdata_q;
  end

  // single-port memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    if (mem_re) mem_rdata_q <= mem[mem_addr];
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (op_i == ebc_pkg::OP_OUT) begin
      read_data_o           <= (mode_q == ebc_pkg::MODE_READ) ? mem_rdata_q : 8'd0;
      accumulator_o         <= a_q;
      reg_b_out_o           <= b_q;
      reg_c_out_o           <= c_q;
      reg_d_out_o           <= d_q;
      reg_e_out_o           <= e_q;
      reg_h_out_o           <= h_q;
      reg_l_out_o           <= l_q;
      stack_pointer_out_o   <= sp_q;
      program_counter_out_o <= pc_q;
      flags_out_o           <= {zf_q, hf_q, cf_q, ime_q};
      unknown_opcode_o      <= unk_q;
    end
  end

endmodule

// File: sv/eight_bit_cpu_execute_core.sv
// eight_bit_cpu_execute_core: top level of the execute core
// depends on ebc_pkg, ebc_ctrl and ebc_dp
//
//   channel | handshake               | payload
//   --------+-------------------------+------------------------------------------
//   in      | in_valid_i / in_ready_o | mode_i, address_i, write_data_i
//   out     | out_valid_o/out_ready_i | read_data_o .. unknown_opcode_o
//
// memory write, read and register reset run their command state, then the done state
// an instruction makes each memory access (opcode, immediates, operand, interrupt
// registers, pushes) in its own state on the single memory port
// after reset a clearing pass writes zero to all 65536 bytes, one per cycle,
// before the first transaction is accepted
// one transaction in flight; the next is taken while the result waits
module eight_bit_cpu_execute_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  write_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  read_data_o,
  output logic [7:0]  accumulator_o,
  output logic [7:0]  reg_b_out_o,
  output logic [7:0]  reg_c_out_o,
  output logic [7:0]  reg_d_out_o,
  output logic [7:0]  reg_e_out_o,
  output logic [7:0]  reg_h_out_o,
  output logic [7:0]  reg_l_out_o,
  output logic [15:0] stack_pointer_out_o,
  output logic [15:0] program_counter_out_o,
  output logic [3:0]  flags_out_o,
  output logic        unknown_opcode_o
);

  ebc_pkg::dp_op_e  dp_op;
  ebc_pkg::status_t status;

  // sequencer
  ebc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_mode_i   (mode_i),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .op_o        (dp_op)
  );

  // datapath
  ebc_dp u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .op_i                  (dp_op),
    .mode_i                (mode_i),
    .address_i             (address_i),
    .write_data_i          (write_data_i),
    .status_o              (status),
    .read_data_o           (read_data_o),
    .accumulator_o         (accumulator_o),
    .reg_b_out_o           (reg_b_out_o),
    .reg_c_out_o           (reg_c_out_o),
    .reg_d_out_o           (reg_d_out_o),
    .reg_e_out_o           (reg_e_out_o),
    .reg_h_out_o           (reg_h_out_o),
    .reg_l_out_o           (reg_l_out_o),
    .stack_pointer_out_o   (stack_pointer_out_o),
    .program_counter_out_o (program_counter_out_o),
    .flags_out_o           (flags_out_o),
    .unknown_opcode_o      (unknown_opcode_o)
  );

  // an accepted transaction keeps the block busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken again right after accept");

  // loading the result raises valid
  a_out_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dp_op == ebc_pkg::OP_OUT) |=> out_valid_o)
    else $error("result loaded without valid");

  // servicing an interrupt clears the master enable
  a_ime_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dp_op == ebc_pkg::OP_WR_IF) |=> !status.ime)
    else $error("master enable still set after interrupt entry");

endmodule
